[rtl/ile_pkg.sv]
// Package for the indexed list engine: operation codes, transfer payload
// types and the command/status structs between controller and datapath.
// No dependencies.
package ile_pkg;

    // Default list capacity
    localparam int MAX_ENTRIES_DEF = 64;

    // Operation codes carried in the op field
    typedef enum logic [2:0] {
        OP_READ     = 3'd0,
        OP_INS_HEAD = 3'd1,
        OP_INS_TAIL = 3'd2,
        OP_INS_POS  = 3'd3,
        OP_DELETE   = 3'd4
    } op_t;

    // Input item
    typedef struct packed {
        logic [2:0]          op;
        logic signed [15:0]  position;
        logic signed [31:0]  value;
    } in_item_t;

    // Result item
    typedef struct packed {
        logic signed [31:0]  read_value;
        logic                found;
        logic                accepted;
        logic [6:0]          length;
    } out_item_t;

    // Controller to datapath commands
    typedef struct packed {
        logic capture;     // latch the incoming item and its range checks
        logic mem_read;    // read the entry at the pointer
        logic shift_step;  // one move of the shift loop
        logic commit;      // final write and count update
        logic emit;        // load the result register
    } ctrl_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic modify;      // the item changes the list
        logic shift_done;  // no moves left, no write pending
        logic out_free;    // result register can take a new result
    } ctrl_stat_t;

endpackage

[rtl/indexed_list_engine.sv]
// Top level of the indexed list engine: ordered list of signed 32-bit values.
// Instantiates ile_controller and ile_datapath; depends on ile_pkg.
//
//   channel  | signals                           | payload
//   ---------+-----------------------------------+------------
//   item     | item_valid in, item_stall out     | in_item_t
//   result   | result_valid out, result_stall in | out_item_t
//
// One item at a time. A read, or an insert/delete that leaves the list as
// it is, goes from capture through the decide state to the result load. A
// changing insert or delete moves k entries through the memory, one read and
// one write per cycle, then commits before the result load.
// Reset empties the list; no clearing pass is needed.
// A result waits in its output register while result_stall is high; the
// next item is taken once that result is loaded.
module indexed_list_engine
    import ile_pkg::*;
#(
    parameter int MAX_ENTRIES = MAX_ENTRIES_DEF
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      item_valid,
    output logic      item_stall,
    input  in_item_t  item,
    output logic      result_valid,
    input  logic      result_stall,
    output out_item_t result
);

    ctrl_cmd_t  cmd;
    ctrl_stat_t stat;

    ile_controller u_ctrl
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .stat       (stat),
        .cmd        (cmd)
    );

    ile_datapath #(
        .MAX_ENTRIES (MAX_ENTRIES)
    ) u_dp
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .item         (item),
        .cmd          (cmd),
        .stat         (stat),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

endmodule

[rtl/ile_datapath.sv]
// Datapath of the indexed list engine: entry memory, count, shift pointers
// and the result register. Depends on ile_pkg.
module ile_datapath
    import ile_pkg::*;
#(
    parameter int MAX_ENTRIES = MAX_ENTRIES_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  in_item_t   item,
    input  ctrl_cmd_t  cmd,
    output ctrl_stat_t stat,
    output logic       result_valid,
    input  logic       result_stall,
    output out_item_t  result
);

    localparam int IDX_W = $clog2(MAX_ENTRIES);
    localparam int CNT_W = $clog2(MAX_ENTRIES + 1);

    // Entry storage
    logic [31:0] mem [MAX_ENTRIES];

    // Control registers
    logic [CNT_W-1:0] count_reg, count_next;
    logic             pend_reg, pend_next;
    logic             result_valid_reg, result_valid_next;

    // Payload registers
    logic [2:0]        op_reg;
    logic [31:0]       val_reg;
    logic [IDX_W-1:0]  slot_reg;
    logic              is_ins_reg;
    logic              mod_reg;
    logic              hit_reg;
    logic [CNT_W-1:0]  ptr_reg, ptr_next;
    logic [CNT_W-1:0]  rem_reg, rem_next;
    logic [IDX_W-1:0]  pend_addr_reg, pend_addr_next;
    logic [31:0]       rdata_reg;
    out_item_t         result_reg;

    // Capture-time checks
    logic        pos_neg;
    logic [15:0] pos_u;
    logic [15:0] cnt16;
    logic        in_range;
    logic        full;
    logic [15:0] slot16;
    logic        ins_op;
    logic        ins_ok;

    // Memory port
    logic             mem_we;
    logic             mem_re;
    logic [IDX_W-1:0] waddr;
    logic [31:0]      wdata;

    // Range checks on the incoming item
    always_comb
    begin
        pos_neg  = item.position[15];
        pos_u    = item.position;
        cnt16    = 16'(count_reg);
        in_range = !pos_neg && (pos_u < cnt16);
        full     = (count_reg == CNT_W'(MAX_ENTRIES));
        ins_op   = (item.op inside {OP_INS_HEAD, OP_INS_TAIL, OP_INS_POS});
        case (item.op)
            OP_INS_HEAD: slot16 = '0;
            OP_INS_TAIL: slot16 = cnt16;
            OP_INS_POS:  slot16 = pos_neg ? 16'd0 : pos_u;
            default:     slot16 = '0;
        endcase
        ins_ok = !full && (slot16 <= cnt16);
    end

    // Memory port selection
    always_comb
    begin
        mem_re = cmd.mem_read || (cmd.shift_step && (rem_reg != '0));
        mem_we = (cmd.shift_step && pend_reg) || (cmd.commit && is_ins_reg);
        waddr  = cmd.commit ? slot_reg : pend_addr_reg;
        wdata  = cmd.commit ? val_reg : rdata_reg;
    end

    // Shift loop: one read and one write per cycle
    always_comb
    begin
        ptr_next       = ptr_reg;
        rem_next       = rem_reg;
        pend_next      = pend_reg;
        pend_addr_next = pend_addr_reg;
        count_next     = count_reg;
        if (cmd.capture)
        begin
            pend_next = 1'b0;
            if (item.op == OP_READ)
            begin
                ptr_next = CNT_W'(pos_u);
            end
            else if (item.op == OP_DELETE)
            begin
                ptr_next = CNT_W'(pos_u) + CNT_W'(1);
                rem_next = count_reg - CNT_W'(pos_u) - CNT_W'(1);
            end
            else
            begin
                ptr_next = count_reg - CNT_W'(1);
                rem_next = count_reg - CNT_W'(slot16);
            end
        end
        else if (cmd.shift_step)
        begin
            if (rem_reg != '0)
            begin
                pend_next = 1'b1;
                rem_next  = rem_reg - CNT_W'(1);
                if (is_ins_reg)
                begin
                    pend_addr_next = ptr_reg[IDX_W-1:0] + IDX_W'(1);
                    ptr_next       = ptr_reg - CNT_W'(1);
                end
                else
                begin
                    pend_addr_next = ptr_reg[IDX_W-1:0] - IDX_W'(1);
                    ptr_next       = ptr_reg + CNT_W'(1);
                end
            end
            else
            begin
                pend_next = 1'b0;
            end
        end
        else if (cmd.commit)
        begin
            count_next = is_ins_reg ? count_reg + CNT_W'(1) : count_reg - CNT_W'(1);
        end
    end

    // Result register handshake
    always_comb
    begin
        result_valid_next = result_valid_reg;
        if (cmd.emit)
        begin
            result_valid_next = 1'b1;
        end
        else if (!result_stall)
        begin
            result_valid_next = 1'b0;
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg        <= '0;
            pend_reg         <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg        <= count_next;
            pend_reg         <= pend_next;
            result_valid_reg <= result_valid_next;
        end
    end

    // Item payload and pointers
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg     <= item.op;
            val_reg    <= item.value;
            slot_reg   <= IDX_W'(slot16);
            is_ins_reg <= ins_op;
            mod_reg    <= (ins_op && ins_ok) || ((item.op == OP_DELETE) && in_range);
            hit_reg    <= (item.op == OP_READ) && in_range;
        end
        ptr_reg       <= ptr_next;
        rem_reg       <= rem_next;
        pend_addr_reg <= pend_addr_next;
    end

    // Entry memory, registered read
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[waddr] <= wdata;
        end
        if (mem_re)
        begin
            rdata_reg <= mem[ptr_reg[IDX_W-1:0]];
        end
    end

    // Result register
    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            if (op_reg == OP_READ)
            begin
                result_reg.read_value <= hit_reg ? rdata_reg : 32'hFFFF_FFFF;
            end
            else
            begin
                result_reg.read_value <= '0;
            end
            result_reg.found    <= hit_reg;
            result_reg.accepted <= mod_reg;
            result_reg.length   <= 7'(count_reg);
        end
    end

    // Status to controller
    assign stat.modify     = mod_reg;
    assign stat.shift_done = (rem_reg == '0) && !pend_reg;
    assign stat.out_free   = !result_valid_reg || !result_stall;

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

[rtl/ile_controller.sv]
// Controller of the indexed list engine: sequences capture, shift, commit
// and result load. Depends on ile_pkg.
module ile_controller
    import ile_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       item_valid,
    output logic       item_stall,
    input  ctrl_stat_t stat,
    output ctrl_cmd_t  cmd
);

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_DECIDE = 5'b00010,
        S_SHIFT  = 5'b00100,
        S_FINISH = 5'b01000,
        S_OUT    = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        item_stall = 1'b1;
        case (state_reg)
            S_IDLE:
            begin
                item_stall = 1'b0;
                if (item_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                // read op fetches its entry here; harmless for the others
                cmd.mem_read = 1'b1;
                state_next   = stat.modify ? S_SHIFT : S_OUT;
            end
            S_SHIFT:
            begin
                if (stat.shift_done)
                begin
                    state_next = S_FINISH;
                end
                else
                begin
                    cmd.shift_step = 1'b1;
                end
            end
            S_FINISH:
            begin
                cmd.commit = 1'b1;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (stat.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

[tb/tb_indexed_list_engine.sv]
// Self-checking testbench for indexed_list_engine: directed corner cases, fill to
// capacity, random mixed operations and drain to empty, checked against a mirror list.
// Depends on ile_pkg and the indexed_list_engine RTL.
`timescale 1ns / 1ps

module tb_indexed_list_engine;
    import ile_pkg::*;

    localparam int LIST_DEPTH     = MAX_ENTRIES_DEF;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int SETTLE_CYCLES  = 80;
    // op codes the block does not decode
    localparam logic [2:0] OP_SPARE_LO = 3'd5;
    localparam logic [2:0] OP_SPARE_HI = 3'd7;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      item_valid = 1'b0;
    logic      item_stall;
    in_item_t  item = '0;
    logic      result_valid;
    logic      result_stall = 1'b0;
    out_item_t result;

    // mirror of the list contents and length, updated at each accepted transfer
    logic signed [31:0] list_mirror [LIST_DEPTH];
    int                 list_len = 0;
    out_item_t          pending_results [$];

    int error_count  = 0;
    int quiet_cycles = 0;
    int stall_left   = 0;
    bit idle_enable  = 1'b1;
    bit stall_enable = 1'b1;

    indexed_list_engine DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    initial begin
        forever #4 clk = ~clk;
    end

    // ---------------------------------------------------------------
    // Mirror list
    // ---------------------------------------------------------------
    function automatic bit mirror_insert(int slot, logic signed [31:0] val);
        if (list_len >= LIST_DEPTH || slot > list_len)
            return 1'b0;
        for (int i = list_len; i > slot; i--)
            list_mirror[i] = list_mirror[i - 1];
        list_mirror[slot] = val;
        list_len++;
        return 1'b1;
    endfunction

    // Apply one operation to the mirror and return the result it must produce
    function automatic out_item_t apply_list_op(in_item_t it);
        out_item_t r;
        int        pos;
        r   = '0;
        pos = $signed(it.position);
        case (it.op)
            OP_READ: begin
                if (pos >= 0 && pos < list_len) begin
                    r.read_value = list_mirror[pos];
                    r.found      = 1'b1;
                end else begin
                    r.read_value = -32'sd1;
                end
            end
            OP_INS_HEAD: r.accepted = mirror_insert(0, it.value);
            OP_INS_TAIL: r.accepted = mirror_insert(list_len, it.value);
            OP_INS_POS:  r.accepted = mirror_insert((pos < 0) ? 0 : pos, it.value);
            OP_DELETE: begin
                if (pos >= 0 && pos < list_len) begin
                    for (int i = pos; i + 1 < list_len; i++)
                        list_mirror[i] = list_mirror[i + 1];
                    list_len--;
                    r.accepted = 1'b1;
                end
            end
            default: ;
        endcase
        r.length = list_len[6:0];
        return r;
    endfunction

    // ---------------------------------------------------------------
    // Random helpers
    // ---------------------------------------------------------------
    // mostly back-to-back or short gaps, now and then a long one
    function automatic int pick_gap();
        int roll;
        if (!idle_enable)
            return 0;
        roll = $urandom_range(0, 99);
        if (roll < 50)
            return 0;
        if (roll < 85)
            return $urandom_range(1, 3);
        if (roll < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    function automatic logic signed [31:0] pick_value();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 10)
            return 32'sh8000_0000;
        if (roll < 20)
            return 32'sh7fff_ffff;
        if (roll < 25)
            return -32'sd1;
        if (roll < 30)
            return 32'sd0;
        return $urandom;
    endfunction

    // mostly inside the list or on its edge, some far out in both directions
    function automatic int pick_position();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 65)
            return $urandom_range(0, list_len);
        if (roll < 75)
            return list_len + $urandom_range(0, 1);
        if (roll < 87)
            return -$urandom_range(1, 32768);
        return $urandom_range(0, 32767);
    endfunction

    // ---------------------------------------------------------------
    // Item channel driver
    // ---------------------------------------------------------------
    task automatic send_item(input logic [2:0] op, input logic signed [15:0] pos,
                             input logic signed [31:0] val);
        in_item_t it;
        int       gap;
        gap = pick_gap();
        if (gap > 0) begin
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        it.op       = op;
        it.position = pos;
        it.value    = val;
        item       <= it;
        item_valid <= 1'b1;
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
        pending_results.push_back(apply_list_op(it));
    endtask

    // hold the item channel until every outstanding result has come back
    task automatic wait_for_results();
        item_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    // ---------------------------------------------------------------
    // Result channel: random stall, checker, watchdog
    // ---------------------------------------------------------------
    always @(posedge clk) begin : stall_gen
        int roll;
        if (!rst_n || !stall_enable) begin
            result_stall <= 1'b0;
            stall_left   <= 0;
        end else if (stall_left > 0) begin
            result_stall <= 1'b1;
            stall_left   <= stall_left - 1;
        end else begin
            roll = $urandom_range(0, 99);
            if (roll < 60) begin
                result_stall <= 1'b0;
            end else if (roll < 90) begin
                result_stall <= 1'b1;
                stall_left   <= $urandom_range(0, 2);
            end else begin
                result_stall <= 1'b1;
                stall_left   <= $urandom_range(7, 39);
            end
        end
    end

    always @(posedge clk) begin : result_check
        out_item_t want;
        if (rst_n && result_valid && !result_stall) begin
            if (pending_results.size() == 0) begin
                $display("%0t: result with none pending: read_value %0d found %0b "
                         , $time, result.read_value, result.found,
                         "accepted %0b length %0d", result.accepted, result.length);
                error_count++;
            end else begin
                want = pending_results.pop_front();
                if (result.read_value !== want.read_value) begin
                    $display("%0t: read_value expected %0d actual %0d",
                             $time, want.read_value, result.read_value);
                    error_count++;
                end
                if (result.found !== want.found) begin
                    $display("%0t: found expected %0b actual %0b",
                             $time, want.found, result.found);
                    error_count++;
                end
                if (result.accepted !== want.accepted) begin
                    $display("%0t: accepted expected %0b actual %0b",
                             $time, want.accepted, result.accepted);
                    error_count++;
                end
                if (result.length !== want.length) begin
                    $display("%0t: length expected %0d actual %0d",
                             $time, want.length, result.length);
                    error_count++;
                end
            end
        end
    end

    // end the run if neither channel moves for too long
    always @(posedge clk) begin
        if ((item_valid && !item_stall) || (result_valid && !result_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------
    // empty list misses, position extremes, spare ops, head/tail/end inserts
    task automatic test_directed_corners();
        send_item(OP_READ, 16'sd0, 32'sd0);
        send_item(OP_READ, -16'sd1, 32'sd0);
        send_item(OP_READ, 16'sh7fff, 32'sd0);
        send_item(OP_DELETE, 16'sd0, 32'sd0);
        send_item(OP_DELETE, 16'sh8000, 32'sd0);
        send_item(OP_INS_POS, 16'sd1, 32'sd5);
        for (int op = OP_SPARE_LO; op <= OP_SPARE_HI; op++)
            send_item(op[2:0], -16'sd1, -32'sd1);
        // negative position goes to the head
        send_item(OP_INS_POS, 16'sh8000, 32'sh8000_0000);
        send_item(OP_INS_TAIL, 16'sd0, 32'sh7fff_ffff);
        send_item(OP_INS_HEAD, 16'sh7fff, -32'sd1);
        // insert exactly at the end, then one past it
        send_item(OP_INS_POS, 16'sd3, 32'sd0);
        send_item(OP_INS_POS, 16'sd5, 32'sd9);
        for (int p = 0; p <= 4; p++)
            send_item(OP_READ, p[15:0], 32'sd0);
        send_item(OP_READ, 16'sh8000, 32'sd0);
        send_item(OP_DELETE, 16'sd4, 32'sd0);
        send_item(OP_DELETE, 16'sd3, 32'sd0);
        send_item(OP_DELETE, 16'sd0, 32'sd0);
        send_item(OP_DELETE, 16'sh7fff, 32'sd0);
    endtask

    // fill the list, hit it with inserts and edge reads while full, then delete and reinsert
    task automatic test_fill_to_capacity();
        logic [2:0] op;
        while (list_len < LIST_DEPTH) begin
            case ($urandom_range(0, 2))
                0:       op = OP_INS_HEAD;
                1:       op = OP_INS_TAIL;
                default: op = OP_INS_POS;
            endcase
            send_item(op, 16'($urandom_range(0, list_len + 2) - 2), pick_value());
        end
        send_item(OP_INS_HEAD, 16'sd0, 32'sd1);
        send_item(OP_INS_TAIL, 16'sd0, 32'sd2);
        send_item(OP_INS_POS, 16'sd0, 32'sd3);
        send_item(OP_INS_POS, 16'(LIST_DEPTH), 32'sd4);
        send_item(OP_READ, 16'(LIST_DEPTH - 1), 32'sd0);
        send_item(OP_READ, 16'(LIST_DEPTH), 32'sd0);
        wait_for_results();
        send_item(OP_DELETE, 16'(LIST_DEPTH - 1), 32'sd0);
        send_item(OP_INS_POS, 16'(LIST_DEPTH - 1), pick_value());
        send_item(OP_DELETE, 16'sd0, 32'sd0);
    endtask

    // phases of random ops, weighted to push the length up or down
    task automatic test_random_mix();
        int         ins_weight;
        int         roll;
        logic [2:0] op;
        for (int n = 0; n < 300; n++) begin
            if (n % 50 == 0) begin
                ins_weight   = (n % 100 == 0) ? $urandom_range(10, 40) : $urandom_range(60, 90);
                idle_enable  = ((n / 50) % 3 != 2);
                stall_enable <= ((n / 50) % 4 != 1);
            end
            roll = $urandom_range(0, 99);
            if (roll < ins_weight) begin
                case ($urandom_range(0, 2))
                    0:       op = OP_INS_HEAD;
                    1:       op = OP_INS_TAIL;
                    default: op = OP_INS_POS;
                endcase
            end else begin
                roll = $urandom_range(0, 19);
                if (roll < 9)
                    op = OP_READ;
                else if (roll < 18)
                    op = OP_DELETE;
                else
                    op = 3'($urandom_range(OP_SPARE_LO, OP_SPARE_HI));
            end
            send_item(op, 16'(pick_position()), pick_value());
        end
        idle_enable  = 1'b1;
        stall_enable <= 1'b1;
    endtask

    // delete everything at random positions, checking reads along the way
    task automatic test_drain_to_empty();
        wait_for_results();
        while (list_len > 0) begin
            if ($urandom_range(0, 3) == 0)
                send_item(OP_READ, 16'($urandom_range(0, list_len - 1)), 32'sd0);
            send_item(OP_DELETE, 16'($urandom_range(0, list_len - 1)), pick_value());
        end
        send_item(OP_READ, 16'sd0, 32'sd0);
        send_item(OP_DELETE, 16'sd0, 32'sd0);
    endtask

    initial begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed_corners();
        test_fill_to_capacity();
        test_random_mix();
        test_drain_to_empty();
        wait_for_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

[filelist.f]
rtl/ile_pkg.sv
rtl/ile_datapath.sv
rtl/ile_controller.sv
rtl/indexed_list_engine.sv
tb/tb_indexed_list_engine.sv
